// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the checker files of the button click classifier.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge while reset is released.
`define BCC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Checked on every clock edge, reset included.
`define BCC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: hw/rtl/bcc_pkg.sv
// Types and constants of the button click classifier.
// Used by bcc_step, button_click_classifier_core and bcc_checker.
package bcc_pkg;

    typedef logic [1:0] t_mode;
    localparam t_mode MODE_TICK  = 2'd0;
    localparam t_mode MODE_EDGE  = 2'd1;
    localparam t_mode MODE_READ  = 2'd2;
    localparam t_mode MODE_CLEAR = 2'd3;

    typedef logic [2:0] t_state;
    localparam t_state ST_NONE   = 3'd0;
    localparam t_state ST_SHORT  = 3'd1;
    localparam t_state ST_LONG   = 3'd2;
    localparam t_state ST_DOUBLE = 3'd3;
    localparam t_state ST_WAIT   = 3'd4;

    typedef logic [1:0] t_reg_idx;
    localparam t_reg_idx REG_LONG_PRESS   = 2'd0;
    localparam t_reg_idx REG_DOUBLE_CLICK = 2'd1;
    localparam t_reg_idx REG_PIN_MASK     = 2'd2;

    localparam int PIN_W      = 16;
    localparam int CFG_W      = 16;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 8;

    localparam logic [CFG_W-1:0] LONG_PRESS_RST   = 16'd500;
    localparam logic [CFG_W-1:0] DOUBLE_CLICK_RST = 16'd300;
    localparam logic [CFG_W-1:0] PIN_MASK_RST     = 16'd1;

    typedef struct packed {
        logic [CFG_W-1:0] hold_limit;
        logic [CFG_W-1:0] double_click_ticks;
        logic [PIN_W-1:0] pin_mask;
    } t_cfg;

endpackage

// File: hw/rtl/bcc_step.sv
// Next-state logic of the button click classifier for one input word.
// Depends on bcc_pkg.
module bcc_step #(
    parameter int TIME_WIDTH = 32
) (
    input  bcc_pkg::t_mode             i_mode,
    input  logic [bcc_pkg::PIN_W-1:0]  i_pin,
    input  logic                       i_level,
    input  bcc_pkg::t_cfg              i_cfg,
    input  bcc_pkg::t_state            i_state,
    input  logic [bcc_pkg::CFG_W-1:0]  i_window,
    input  logic [TIME_WIDTH-1:0]      i_time,
    input  logic [TIME_WIDTH-1:0]      i_stamp,
    output bcc_pkg::t_state            o_state,
    output logic [bcc_pkg::CFG_W-1:0]  o_window,
    output logic [TIME_WIDTH-1:0]      o_time,
    output logic [TIME_WIDTH-1:0]      o_stamp
);
    import bcc_pkg::*;

    logic [TIME_WIDTH-1:0] held;
    logic                  is_long;

    // Hold time wraps with the millisecond clock.
    assign held    = i_time - i_stamp;
    assign is_long = held > TIME_WIDTH'(i_cfg.hold_limit);

    always_comb begin
        o_state  = i_state;
        o_window = i_window;
        o_time   = i_time;
        o_stamp  = i_stamp;
        unique case (i_mode)
            MODE_TICK: begin
                o_time = i_time + TIME_WIDTH'(1);
                if (i_window != '0) begin
                    o_window = i_window - CFG_W'(1);
                end
            end
            MODE_EDGE: begin
                if (i_pin != i_cfg.pin_mask) begin
                    o_state = ST_NONE;
                end else if (!i_level) begin
                    o_stamp = i_time;
                end else if (is_long) begin
                    o_state = ST_LONG;
                end else if (i_state != ST_WAIT) begin
                    o_state  = ST_WAIT;
                    o_window = i_cfg.double_click_ticks;
                end else begin
                    // A second short release counts even after the window ran out,
                    // as long as no read has turned the wait into a short press.
                    o_state  = ST_DOUBLE;
                    o_window = '0;
                end
            end
            MODE_READ: begin
                if (i_state == ST_WAIT && i_window == '0) begin
                    o_state = ST_SHORT;
                end
            end
            default: begin
                o_state = ST_NONE;
            end
        endcase
    end

endmodule

// File: hw/rtl/button_click_classifier_core.sv
// Top level of the button click classifier: input register, state update, result register.
// Depends on bcc_pkg and bcc_step.
//
//  Channel  | Direction | Words
//  ---------+-----------+--------------------------------------------------
//  s_axis   | in        | tdata {level, pin}, tuser mode; one word per event
//  m_axis   | out       | tdata click class; one word per accepted input
//  cfg      | in        | register index and 16-bit value
//
// Each word passes through the input register before the state update loads the result
// register, from which its result is offered.
// One word per cycle is sustained; the only stall comes from m_axis_tready.
// Reset clears the valid flags, the state, the timers and loads register defaults.
// Configuration writes are taken in any cycle; the port is always ready.
module button_click_classifier_core #(
    parameter int TIME_WIDTH = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [bcc_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // pin[15:0], level[16]
    input  bcc_pkg::t_mode                     s_axis_tuser,  // mode[1:0]
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [bcc_pkg::OUT_DATA_W-1:0]     m_axis_tdata,  // click_class[2:0]
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  bcc_pkg::t_reg_idx                  i_cfg_index,
    input  logic [bcc_pkg::CFG_W-1:0]          i_cfg_data
);
    import bcc_pkg::*;

    t_cfg                  r_cfg;
    logic                  r_in_vld;
    t_mode                 r_in_mode;
    logic [PIN_W-1:0]      r_in_pin;
    logic                  r_in_level;
    t_state                r_state;
    logic [CFG_W-1:0]      r_window;
    logic [TIME_WIDTH-1:0] r_time;
    logic [TIME_WIDTH-1:0] r_stamp;
    logic                  r_out_vld;
    t_state                r_out_state;

    t_state                n_state;
    logic [CFG_W-1:0]      n_window;
    logic [TIME_WIDTH-1:0] n_time;
    logic [TIME_WIDTH-1:0] n_stamp;

    logic in_take;
    logic advance;

    assign advance       = r_in_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = OUT_DATA_W'(r_out_state);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hold_limit         <= LONG_PRESS_RST;
            r_cfg.double_click_ticks <= DOUBLE_CLICK_RST;
            r_cfg.pin_mask           <= PIN_MASK_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_LONG_PRESS:   r_cfg.hold_limit         <= i_cfg_data;
                REG_DOUBLE_CLICK: r_cfg.double_click_ticks <= i_cfg_data;
                REG_PIN_MASK:     r_cfg.pin_mask           <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_take) begin
            r_in_vld <= 1'b1;
        end else if (advance) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_mode  <= s_axis_tuser;
            r_in_pin   <= s_axis_tdata[PIN_W-1:0];
            r_in_level <= s_axis_tdata[PIN_W];
        end
    end

    bcc_step #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_step (
        .i_mode   (r_in_mode),
        .i_pin    (r_in_pin),
        .i_level  (r_in_level),
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .i_window (r_window),
        .i_time   (r_time),
        .i_stamp  (r_stamp),
        .o_state  (n_state),
        .o_window (n_window),
        .o_time   (n_time),
        .o_stamp  (n_stamp)
    );

    // Classifier state and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_NONE;
            r_window  <= '0;
            r_time    <= '0;
            r_stamp   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (advance) begin
                r_state   <= n_state;
                r_window  <= n_window;
                r_time    <= n_time;
                r_stamp   <= n_stamp;
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_state <= n_state;
        end
    end

endmodule

// File: hw/rtl/bcc_checker.sv
// Port-level checks of the button click classifier, bound to its top level.
// Depends on bcc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bcc_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           s_axis_tready,
    input logic [bcc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready
);
    import bcc_pkg::*;

    // The input side only backs up when the output side is stalled.
    `BCC_ASSERT(a_in_stall_cause, i_clk, i_rst_n,
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready),
        "input stalled without output back-pressure")

    // A delivered state is always one of the five defined codes.
    `BCC_ASSERT(a_state_code, i_clk, i_rst_n,
        m_axis_tvalid |-> (m_axis_tdata <= OUT_DATA_W'(ST_WAIT)),
        "undefined button state on output")

    // No result is offered in the cycle after reset.
    `BCC_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !m_axis_tvalid,
        "result valid right after reset")

    // A stalled result keeps its word.
    `BCC_ASSERT(a_out_hold, i_clk, i_rst_n,
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)),
        "stalled result changed")

endmodule

bind button_click_classifier_core bcc_checker u_bcc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
);
